[design/bgq_pkg.sv]
// Shared types and constants for the beat grid quantizer.
`default_nettype none
package bgq_pkg;
  localparam int MaxSlots = 16;
  localparam int CarryDepth = 8;
  localparam int TimeBits = 24;
  localparam int LenBits = 20;
  localparam int CntBits = 5;
  localparam int SlotIdxBits = $clog2(MaxSlots + 1);
  localparam int CarryIdxBits = (CarryDepth > 1) ? $clog2(CarryDepth) : 1;
  localparam int CarryFillBits = $clog2(CarryDepth + 1);
  localparam int QDepth = 2;
  localparam int ProdBits = TimeBits + SlotIdxBits;

  localparam logic [0:0] OP_IMPULSE = 1'b0;
  localparam logic [0:0] OP_BEAT_END = 1'b1;

  localparam logic [0:0] CFG_BEAT_LENGTH = 1'b0;
  localparam logic [0:0] CFG_SLOT_COUNT = 1'b1;

  typedef struct packed {
    logic [0:0] op;
    logic [TimeBits-1:0] t;
  } cmd_t;

  localparam logic [5:0] SNAP_TABLE [6] = '{6'h22, 6'h28, 6'h24, 6'h30, 6'h0C, 6'h2A};

  function automatic logic [4:0] ones16(input logic [15:0] v);
    logic [4:0] n;
    n = '0;
    for (int k = 0; k < 16; k++) n = n + {4'd0, v[k]};
    return n;
  endfunction

  function automatic logic [15:0] snap6(input logic [15:0] p);
    logic [4:0] w;
    logic [4:0] best;
    logic [4:0] d;
    logic [15:0] res;
    w = ones16(p);
    best = 5'd6;
    res = p;
    for (int k = 0; k < 6; k++) begin
      d = ones16({10'd0, p[5:0] ^ SNAP_TABLE[k]});
      if (ones16({10'd0, SNAP_TABLE[k]}) == w && d < best) begin
        best = d;
        res = {10'd0, SNAP_TABLE[k]};
      end
    end
    return res;
  endfunction
endpackage
`default_nettype wire

[design/bgq_ram.sv]
// Generic single-port write, registered-read RAM.
`default_nettype none
module bgq_ram #(
  parameter int Width = 8,
  parameter int Depth = 8
) (
  input  wire logic clk,
  input  wire logic we,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr,
  input  wire logic [Width-1:0] wdata,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr,
  output logic [Width-1:0] rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[design/bgq_front.sv]
// Front end: accepts transactions and queues commands.
`default_nettype none
module bgq_front (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_push,
  output logic in_full,
  input  wire logic [0:0] in_op,
  input  wire logic [bgq_pkg::TimeBits-1:0] in_impulse_time,
  output logic q_valid,
  output bgq_pkg::cmd_t q_cmd,
  input  wire logic q_take
);
  bgq_pkg::cmd_t q_r [bgq_pkg::QDepth];
  logic [1:0] cnt_r, cnt_nxt;
  logic rd_r, rd_nxt, wr_r, wr_nxt;
  logic push_ok, take_ok;
  bgq_pkg::cmd_t in_cmd;

  assign in_full = (cnt_r == 2'(bgq_pkg::QDepth));
  assign push_ok = in_push && !in_full;
  assign take_ok = q_take && q_valid;
  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd = q_r[rd_r];
  always_comb begin
    in_cmd.op = in_op;
    in_cmd.t = in_impulse_time;
    cnt_nxt = cnt_r + {1'b0, push_ok} - {1'b0, take_ok};
    rd_nxt = rd_r ^ take_ok;
    wr_nxt = wr_r ^ push_ok;
  end
  always_ff @(posedge clk) begin
    if (push_ok) q_r[wr_r] <= in_cmd;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r <= 1'b0;
      wr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      rd_r <= rd_nxt;
      wr_r <= wr_nxt;
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'(bgq_pkg::QDepth)) else $error("queue count overflow");
  a_full_no_grow: assert property (@(posedge clk) disable iff (!rst_n)
    in_full && !take_ok |=> in_full) else $error("full dropped without take");
  a_empty_take: assert property (@(posedge clk) disable iff (!rst_n)
    !q_valid |-> !take_ok) else $error("take from empty queue");
`endif
endmodule
`default_nettype wire

[design/bgq_back.sv]
// Back end: grid walk per impulse, carry store replay, pattern output.
`default_nettype none
module bgq_back (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic q_valid,
  input  wire bgq_pkg::cmd_t q_cmd,
  output logic q_take,
  input  wire logic [bgq_pkg::LenBits-1:0] beat_length,
  input  wire logic [bgq_pkg::CntBits-1:0] slot_count,
  output logic out_empty,
  input  wire logic out_pop,
  output logic [15:0] out_pattern,
  output logic out_carry_lost
);
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_WALK = 3'd1;
  localparam logic [2:0] ST_EMIT = 3'd2;
  localparam logic [2:0] ST_RDRQ = 3'd3;
  localparam logic [2:0] ST_RDWT = 3'd4;
  localparam int PB = bgq_pkg::ProdBits;
  localparam int SB = bgq_pkg::SlotIdxBits;

  logic [2:0] st_r, st_nxt;
  logic [PB-1:0] ts_r, ts_nxt, g_r, g_nxt, best_r, best_nxt;
  logic [SB-1:0] i_r, i_nxt, idx_r, idx_nxt;
  logic [bgq_pkg::TimeBits-1:0] t_r, t_nxt;
  logic [bgq_pkg::MaxSlots-1:0] bits_r, bits_nxt;
  logic [bgq_pkg::CarryFillBits-1:0] fill_r, fill_nxt, rn_r, rn_nxt, rp_r, rp_nxt;
  logic lost_r, lost_nxt, replay_r, replay_nxt;
  logic ov_r, ov_nxt;
  logic [15:0] opat_r, opat_nxt;
  logic olost_r, olost_nxt;
  logic we;
  logic [bgq_pkg::CarryIdxBits-1:0] waddr, raddr;
  logic [bgq_pkg::TimeBits-1:0] wdata, rdata;

  logic [bgq_pkg::LenBits-1:0] len;
  logic [SB-1:0] s;
  logic [PB-1:0] d;
  logic [15:0] pat;

  assign len = (beat_length == '0) ? bgq_pkg::LenBits'(1) : beat_length;
  always_comb begin
    if (slot_count == '0) s = SB'(1);
    else if (slot_count > bgq_pkg::CntBits'(bgq_pkg::MaxSlots)) s = SB'(bgq_pkg::MaxSlots);
    else s = SB'(slot_count);
  end
  assign d = (ts_r >= g_r) ? ts_r - g_r : g_r - ts_r;
  assign pat = (s == SB'(6)) ? bgq_pkg::snap6(bits_r[15:0]) : bits_r[15:0];
  assign out_empty = !ov_r;
  assign out_pattern = opat_r;
  assign out_carry_lost = olost_r;

  bgq_ram #(.Width(bgq_pkg::TimeBits), .Depth(bgq_pkg::CarryDepth)) u_carry (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  always_comb begin
    st_nxt = st_r; ts_nxt = ts_r; g_nxt = g_r; best_nxt = best_r;
    i_nxt = i_r; idx_nxt = idx_r; t_nxt = t_r; bits_nxt = bits_r;
    fill_nxt = fill_r; rn_nxt = rn_r; rp_nxt = rp_r; lost_nxt = lost_r;
    replay_nxt = replay_r; ov_nxt = ov_r; opat_nxt = opat_r; olost_nxt = olost_r;
    q_take = 1'b0; we = 1'b0;
    waddr = fill_r[bgq_pkg::CarryIdxBits-1:0];
    wdata = (t_r > bgq_pkg::TimeBits'(len)) ? t_r - bgq_pkg::TimeBits'(len) : '0;
    raddr = rp_r[bgq_pkg::CarryIdxBits-1:0];
    if (ov_r && out_pop) ov_nxt = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        if (q_valid) begin
          if (q_cmd.op == bgq_pkg::OP_IMPULSE) begin
            q_take = 1'b1;
            t_nxt = q_cmd.t;
            ts_nxt = PB'(q_cmd.t) * PB'(s);
            g_nxt = '0; i_nxt = '0; idx_nxt = '0;
            best_nxt = '1;
            replay_nxt = 1'b0;
            st_nxt = ST_WALK;
          end else if (!ov_r || out_pop) begin
            q_take = 1'b1;
            st_nxt = ST_EMIT;
          end
        end
      end
      ST_WALK: begin
        if (d < best_r || i_r == '0) begin
          best_nxt = d;
          idx_nxt = i_r;
        end
        if (i_r == s) begin
          st_nxt = ST_IDLE;
          if (!(d < best_r) && idx_r < s) begin
            bits_nxt = bits_r | (bgq_pkg::MaxSlots'(1) << (s - SB'(1) - idx_r));
          end else if (fill_r < bgq_pkg::CarryFillBits'(bgq_pkg::CarryDepth)) begin
            we = 1'b1;
            fill_nxt = fill_r + bgq_pkg::CarryFillBits'(1);
          end else begin
            lost_nxt = 1'b1;
          end
          if (replay_r) st_nxt = ST_RDRQ;
        end else begin
          i_nxt = i_r + SB'(1);
          g_nxt = g_r + PB'(len);
        end
      end
      ST_EMIT: begin
        ov_nxt = 1'b1;
        opat_nxt = pat;
        olost_nxt = lost_r;
        bits_nxt = '0;
        lost_nxt = 1'b0;
        rn_nxt = fill_r;
        rp_nxt = '0;
        fill_nxt = '0;
        st_nxt = ST_RDRQ;
      end
      ST_RDRQ: begin
        if (rp_r == rn_r) st_nxt = ST_IDLE;
        else st_nxt = ST_RDWT;
      end
      ST_RDWT: begin
        t_nxt = rdata;
        ts_nxt = PB'(rdata) * PB'(s);
        g_nxt = '0; i_nxt = '0; idx_nxt = '0; best_nxt = '1;
        replay_nxt = 1'b1;
        rp_nxt = rp_r + bgq_pkg::CarryFillBits'(1);
        st_nxt = ST_WALK;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    ts_r <= ts_nxt; g_r <= g_nxt; best_r <= best_nxt; i_r <= i_nxt; idx_r <= idx_nxt;
    t_r <= t_nxt; rn_r <= rn_nxt; rp_r <= rp_nxt; opat_r <= opat_nxt; olost_r <= olost_nxt;
    replay_r <= replay_nxt;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      bits_r <= '0;
      fill_r <= '0;
      lost_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      bits_r <= bits_nxt;
      fill_r <= fill_nxt;
      lost_r <= lost_nxt;
      ov_r <= ov_nxt;
    end
  end

`ifndef SYNTHESIS
  a_fill_max: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= bgq_pkg::CarryFillBits'(bgq_pkg::CarryDepth)) else $error("carry overfill");
  a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_take |-> st_r == ST_IDLE) else $error("take outside idle");
  a_emit_sets: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_EMIT |=> ov_r) else $error("emit lost");
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_EMIT |-> !ov_r || $past(out_pop)) else $error("result overwritten");
`endif
endmodule
`default_nettype wire

[design/beat_grid_quantizer_core.sv]
// Beat grid quantizer top level: config registers, front queue, back end.
// Usage:
//  Input channel: push/full with in_op and in_impulse_time. An impulse
//  (op 0) snaps to the nearest grid point of the beat; op 1 ends the beat.
//  Result channel: empty/pop with out_pattern and out_carry_lost, one
//  transaction per end of beat.
//  Config: cfg_valid/cfg_ready write of beat_length (0) or slot_count (1),
//  always ready; write only while idle.
//  Back end: an impulse is taken, then walked over the grid points one by
//  one through a single subtract/compare unit. An end of beat emits the
//  result, then replays each carried impulse: a carry-RAM read, then a walk.
//  With an idle back end an accepted end of beat passes the queue and the
//  emit state before the result register shows it.
//  A two-entry queue decouples input from the back end.
//  Reset: clears slot bits, carry fill, lost flag, queues; beat_length
//  returns to 8000 and slot_count to 6.
//  A stalled receiver holds the result; a next end of beat waits behind it
//  in the back end and the input queue fills up behind that.
`default_nettype none
module beat_grid_quantizer_core (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_push,
  output logic in_full,
  input  wire logic [0:0] in_op,
  input  wire logic [23:0] in_impulse_time,
  output logic out_empty,
  input  wire logic out_pop,
  output logic [15:0] out_pattern,
  output logic out_carry_lost,
  input  wire logic cfg_valid,
  output logic cfg_ready,
  input  wire logic [0:0] cfg_index,
  input  wire logic [19:0] cfg_data
);
  logic [bgq_pkg::LenBits-1:0] len_r;
  logic [bgq_pkg::CntBits-1:0] cnt_r;
  logic q_valid, q_take;
  bgq_pkg::cmd_t q_cmd;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= bgq_pkg::LenBits'(8000);
      cnt_r <= bgq_pkg::CntBits'(6);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        bgq_pkg::CFG_BEAT_LENGTH: len_r <= cfg_data;
        bgq_pkg::CFG_SLOT_COUNT: cnt_r <= cfg_data[bgq_pkg::CntBits-1:0];
        default: ;
      endcase
    end
  end

  bgq_front u_front (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full), .in_op(in_op),
    .in_impulse_time(in_impulse_time), .q_valid(q_valid), .q_cmd(q_cmd), .q_take(q_take)
  );
  bgq_back u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_cmd(q_cmd), .q_take(q_take),
    .beat_length(len_r), .slot_count(cnt_r), .out_empty(out_empty), .out_pop(out_pop),
    .out_pattern(out_pattern), .out_carry_lost(out_carry_lost)
  );
endmodule
`default_nettype wire

[tb/beat_grid_quantizer_core_tb.sv]
// Self-checking testbench for beat_grid_quantizer_core: directed table plus random beats.
`default_nettype none
module beat_grid_quantizer_core_tb;
  localparam int StallLimit = 20000;
  localparam int DrainCycles = 600;
  localparam int HoldCycles = 400;

  typedef struct {
    logic [0:0] op;
    logic [23:0] t;
    bit typed;
    logic [15:0] pat;
    logic lost;
  } stim_row_t;

  typedef struct {
    logic [15:0] pat;
    logic lost;
  } beat_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  logic [0:0] in_op = bgq_pkg::OP_IMPULSE;
  logic [23:0] in_impulse_time = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic [15:0] out_pattern;
  logic out_carry_lost;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [0:0] cfg_index = bgq_pkg::CFG_BEAT_LENGTH;
  logic [19:0] cfg_data = '0;

  beat_grid_quantizer_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_op(in_op), .in_impulse_time(in_impulse_time),
    .out_empty(out_empty), .out_pop(out_pop), .out_pattern(out_pattern),
    .out_carry_lost(out_carry_lost),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // shadow of the block's state
  logic [19:0] beat_len_q;
  logic [4:0] slot_cnt_q;
  logic [15:0] slot_bits_q;
  logic [23:0] carry_q [bgq_pkg::CarryDepth];
  int carry_fill_q;
  logic lost_q;

  beat_result_t pending_beats [$];
  int mismatches = 0;
  bit no_idle = 0;
  bit hold_req = 0;
  int stall_cnt = 0;

  function automatic int unsigned grid_len();
    return (beat_len_q == 0) ? 1 : beat_len_q;
  endfunction

  function automatic int unsigned grid_slots();
    if (slot_cnt_q == 0) return 1;
    if (slot_cnt_q > bgq_pkg::MaxSlots) return bgq_pkg::MaxSlots;
    return slot_cnt_q;
  endfunction

  task automatic place_impulse(input logic [23:0] t);
    longint unsigned len, s, ts, g, d, best;
    int idx;
    len = grid_len();
    s = grid_slots();
    ts = longint'(t) * s;
    best = 0;
    idx = 0;
    for (int i = 0; i <= s; i++) begin
      g = i * len;
      d = (ts >= g) ? ts - g : g - ts;
      if (i == 0 || d < best) begin
        best = d;
        idx = i;
      end
    end
    if (idx < s) slot_bits_q[s - 1 - idx] = 1'b1;
    else if (carry_fill_q < bgq_pkg::CarryDepth) begin
      carry_q[carry_fill_q] = (t > len) ? t - len[23:0] : 24'd0;
      carry_fill_q++;
    end else lost_q = 1'b1;
  endtask

  function automatic logic [15:0] snap_to_table(input logic [15:0] p);
    logic [5:0] entries [6];
    int best;
    int d;
    logic [15:0] res;
    entries = '{6'b100010, 6'b101000, 6'b100100, 6'b110000, 6'b001100, 6'b101010};
    best = 6;
    res = p;
    for (int i = 0; i < 6; i++) begin
      if ($countones(entries[i]) != $countones(p)) continue;
      d = $countones(p[5:0] ^ entries[i]);
      if (d < best) begin
        best = d;
        res = {10'd0, entries[i]};
      end
    end
    return res;
  endfunction

  task automatic close_beat(output beat_result_t r);
    logic [23:0] saved [bgq_pkg::CarryDepth];
    int n;
    r.pat = (grid_slots() == 6) ? snap_to_table(slot_bits_q) : slot_bits_q;
    r.lost = lost_q;
    slot_bits_q = '0;
    lost_q = 1'b0;
    n = carry_fill_q;
    saved = carry_q;
    carry_fill_q = 0;
    for (int i = 0; i < n; i++) place_impulse(saved[i]);
  endtask

  task automatic send_item(input logic [0:0] op, input logic [23:0] t, input bit typed,
                           input logic [15:0] pat, input logic lost);
    beat_result_t r;
    if (!no_idle) begin
      while ($urandom_range(0, 99) < 25) begin
        in_push <= 1'b0;
        @(posedge clk);
      end
    end
    in_push <= 1'b1;
    in_op <= op;
    in_impulse_time <= t;
    @(posedge clk);
    while (in_full) @(posedge clk);
    if (op == bgq_pkg::OP_IMPULSE) place_impulse(t);
    else begin
      close_beat(r);
      if (typed) begin
        r.pat = pat;
        r.lost = lost;
      end
      pending_beats.push_back(r);
    end
  endtask

  task automatic drain();
    in_push <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [19:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == bgq_pkg::CFG_BEAT_LENGTH) beat_len_q = data;
    else slot_cnt_q = data[4:0];
    @(posedge clk);
  endtask

  function automatic logic [23:0] pick_time();
    longint unsigned len, s, g, j;
    int i;
    len = grid_len();
    s = grid_slots();
    case ($urandom_range(0, 9))
      0: return 24'($urandom());
      1: return 24'hFFFFFF;
      2: return 24'd0;
      default: begin
        i = $urandom_range(0, s);
        g = (i * len) / s;
        j = $urandom_range(0, len / s / 2 + 1);
        if ($urandom_range(0, 1) && g >= j) g = g - j;
        else g = g + j;
        return (g > 24'hFFFFFF) ? 24'hFFFFFF : g[23:0];
      end
    endcase
  endfunction

  task automatic random_beats(input int items);
    int sent;
    int n;
    sent = 0;
    while (sent < items) begin
      n = $urandom_range(0, 7);
      for (int k = 0; k < n; k++) send_item(bgq_pkg::OP_IMPULSE, pick_time(), 0, '0, 1'b0);
      if ($urandom_range(0, 9) == 0)
        send_item(bgq_pkg::OP_IMPULSE, 24'($urandom()), 0, '0, 1'b0);
      send_item(bgq_pkg::OP_BEAT_END, 24'($urandom()), 0, '0, 1'b0);
      sent += n + 1;
    end
  endtask

  // receiver
  initial begin
    beat_result_t e;
    forever begin
      @(posedge clk);
      if (out_pop && !out_empty) begin
        if (pending_beats.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected transaction: pattern %h lost %b",
                                         out_pattern, out_carry_lost);
        end else begin
          e = pending_beats.pop_front();
          if (out_pattern !== e.pat || out_carry_lost !== e.lost) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: pattern exp %h got %h, lost exp %b got %b",
                       e.pat, out_pattern, e.lost, out_carry_lost);
          end
        end
      end
      if (hold_req) begin
        hold_req = 0;
        out_pop <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end else if (!rst_n) out_pop <= 1'b0;
      else out_pop <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 25);
    end
  end

  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty) || (cfg_valid && cfg_ready))
      stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= StallLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  stim_row_t dir_rows [] = '{
    '{bgq_pkg::OP_IMPULSE, 24'd0, 0, 16'h0, 1'b0},
    '{bgq_pkg::OP_BEAT_END, 24'd0, 1, 16'h20, 1'b0},
    '{bgq_pkg::OP_BEAT_END, 24'hFFFFFF, 1, 16'h0, 1'b0},
    '{bgq_pkg::OP_IMPULSE, 24'd8000, 0, 16'h0, 1'b0},
    '{bgq_pkg::OP_BEAT_END, 24'd0, 1, 16'h0, 1'b0},
    '{bgq_pkg::OP_BEAT_END, 24'd0, 1, 16'h20, 1'b0},
    '{bgq_pkg::OP_IMPULSE, 24'd2000, 0, 16'h0, 1'b0},
    '{bgq_pkg::OP_IMPULSE, 24'd4000, 0, 16'h0, 1'b0},
    '{bgq_pkg::OP_BEAT_END, 24'd0, 0, 16'h0, 1'b0},
    '{bgq_pkg::OP_IMPULSE, 24'hFFFFFF, 0, 16'h0, 1'b0},
    '{bgq_pkg::OP_IMPULSE, 24'd8000, 0, 16'h0, 1'b0},
    '{bgq_pkg::OP_IMPULSE, 24'd8000, 0, 16'h0, 1'b0},
    '{bgq_pkg::OP_IMPULSE, 24'd8000, 0, 16'h0, 1'b0},
    '{bgq_pkg::OP_IMPULSE, 24'd8000, 0, 16'h0, 1'b0},
    '{bgq_pkg::OP_IMPULSE, 24'd8000, 0, 16'h0, 1'b0},
    '{bgq_pkg::OP_IMPULSE, 24'd8000, 0, 16'h0, 1'b0},
    '{bgq_pkg::OP_IMPULSE, 24'd8000, 0, 16'h0, 1'b0},
    '{bgq_pkg::OP_IMPULSE, 24'd8000, 0, 16'h0, 1'b0},
    '{bgq_pkg::OP_BEAT_END, 24'd0, 1, 16'h0, 1'b1},
    '{bgq_pkg::OP_BEAT_END, 24'd0, 0, 16'h0, 1'b0},
    '{bgq_pkg::OP_IMPULSE, 24'h555555, 0, 16'h0, 1'b0},
    '{bgq_pkg::OP_IMPULSE, 24'hAAAAAA, 0, 16'h0, 1'b0},
    '{bgq_pkg::OP_BEAT_END, 24'd0, 0, 16'h0, 1'b0},
    '{bgq_pkg::OP_BEAT_END, 24'd0, 0, 16'h0, 1'b0}
  };

  logic [19:0] len_set [] = '{20'd1, 20'd1048575, 20'd0, 20'd100, 20'd8000, 20'd3000, 20'd17};
  logic [4:0] slot_set [] = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd6, 5'd4, 5'd17};

  initial begin
    beat_len_q = 20'd8000;
    slot_cnt_q = 5'd6;
    slot_bits_q = '0;
    carry_fill_q = 0;
    lost_q = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i])
      send_item(dir_rows[i].op, dir_rows[i].t, dir_rows[i].typed, dir_rows[i].pat,
                dir_rows[i].lost);
    drain();

    write_reg(bgq_pkg::CFG_BEAT_LENGTH, 20'd8000);
    write_reg(bgq_pkg::CFG_SLOT_COUNT, {15'h7FFF, 5'd6});
    random_beats(150);

    foreach (len_set[p]) begin
      drain();
      write_reg(bgq_pkg::CFG_BEAT_LENGTH, len_set[p]);
      write_reg(bgq_pkg::CFG_SLOT_COUNT, {15'($urandom_range(0, 32767)), slot_set[p]});
      if (p == 1) no_idle = 1;
      if (p == 2) no_idle = 0;
      if (p == 3) hold_req = 1;
      random_beats(p == 4 ? 90 : 130);
      if (p == 4) begin
        drain();
        random_beats(60);
      end
    end

    drain();
    if (pending_beats.size() != 0) mismatches++;
    if (mismatches == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule
`default_nettype wire
